### hw/rtl/bc128_pkg.sv
// ============================================================================
// bc128_pkg - shared types, tables and byte helpers for the 128-bit cipher
// Holds the substitution table, the round constants, the field-doubling
// helper and the control struct passed from the sequencer to the round logic.
// ============================================================================
`default_nettype none

package bc128_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS + 1);
    localparam int unsigned BLOCK_W    = 128;
    localparam int unsigned HALF_W     = 64;

    // Control from the sequencer to the round logic
    typedef struct packed {
        logic [ROUND_W-1:0] round;
        logic               last;
    } t_round_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NUM_ROUNDS+1] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s,
                                            input int unsigned i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bc128_key_step.sv
// ============================================================================
// bc128_key_step - one step of the key schedule
// Derives the next 128-bit round key from the current one and the round
// constant selected by the round number.
// ============================================================================
`default_nettype none

module bc128_key_step
    import bc128_pkg::*;
(
    input  wire t_round_ctl              i_ctl,
    input  wire logic [BLOCK_W-1:0]      i_rk,
    output logic      [BLOCK_W-1:0]      o_rk
);

    logic [31:0] w0, w1, w2, w3;
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;

    assign {w0, w1, w2, w3} = i_rk;

    // Rotate, substitute and fold in the round constant
    assign t = {SBOX[w3[23:16]] ^ RCON[i_ctl.round],
                SBOX[w3[15:8]],
                SBOX[w3[7:0]],
                SBOX[w3[31:24]]};

    // Chain the four words
    assign n0 = w0 ^ t;
    assign n1 = w1 ^ n0;
    assign n2 = w2 ^ n1;
    assign n3 = w3 ^ n2;

    assign o_rk = {n0, n1, n2, n3};

endmodule

`default_nettype wire

### hw/rtl/bc128_round.sv
// ============================================================================
// bc128_round - shared cipher round
// Applies SubBytes and ShiftRows, MixColumns except in the last round, and
// the round key. Reused by the sequencer once per round.
// ============================================================================
`default_nettype none

module bc128_round
    import bc128_pkg::*;
(
    input  wire t_round_ctl              i_ctl,
    input  wire logic [BLOCK_W-1:0]      i_state,
    input  wire logic [BLOCK_W-1:0]      i_rk,
    output logic      [BLOCK_W-1:0]      o_state
);

    logic [7:0] ss  [16];
    logic [7:0] mix [16];
    logic [BLOCK_W-1:0] flat;

    // Substitute and shift rows
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                ss[4*c+r] = SBOX[get_byte(i_state, 4*((c + r) % 4) + r)];
            end
        end
    end

    // Mix each column from its original bytes
    always_comb begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = ss[4*c];
            a1  = ss[4*c+1];
            a2  = ss[4*c+2];
            a3  = ss[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            mix[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            mix[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            mix[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            mix[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
    end

    // Skip the mix in the last round, then pack
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            flat[BLOCK_W-1-8*i -: 8] = i_ctl.last ? ss[i] : mix[i];
        end
    end

    assign o_state = flat ^ i_rk;

endmodule

`default_nettype wire

### hw/rtl/block_cipher_128_encrypt.sv
// ============================================================================
// block_cipher_128_encrypt - AES-128 block encryption, one round per cycle
// Iterative encryptor with a shared round unit and on-the-fly key schedule.
// ============================================================================
// Each 128-bit block is accepted on one beat, which adds the whitening key;
// the shared round unit and the key-schedule step then run once per cycle
// for the ten rounds, so the ciphertext lands in the output register at the
// end of the last round. The input is not ready while a block is in the
// rounds. It is ready again in the cycle after the last round once the
// ciphertext has moved into the output register; if the previous result is
// still waiting there, the new ciphertext is held and the input stays not
// ready until the output register is read. The 128-bit key is written over
// the register port at byte 0 (key bytes 0..7) and byte 8 (key bytes 8..15)
// and takes effect for the next block accepted.
`default_nettype none

module block_cipher_128_encrypt
    import bc128_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [HALF_W-1:0]   pwdata,
    output logic      [HALF_W-1:0]   prdata,
    output logic                     pready,
    // plaintext stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [BLOCK_W-1:0]  s_axis_tdata,  // [63:0] block_high, [127:64] block_low
    // ciphertext stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [BLOCK_W-1:0]  m_axis_tdata   // [63:0] cipher_high, [127:64] cipher_low
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [ROUND_W-1:0]   r_round, n_round;
    logic [BLOCK_W-1:0]   r_blk, n_blk;
    logic [BLOCK_W-1:0]   r_rk, n_rk;
    logic [HALF_W-1:0]    r_key_high, r_key_low;
    logic                 r_out_valid, n_out_valid;
    logic [BLOCK_W-1:0]   r_out, n_out;

    t_round_ctl           ctl;
    logic [BLOCK_W-1:0]   rk_next;
    logic [BLOCK_W-1:0]   round_out;
    logic                 in_beat;
    logic                 out_free;
    logic                 wr_en;

    // Register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = paddr[3] ? r_key_low : r_key_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (wr_en) begin
            if (paddr[3]) begin
                r_key_low <= pwdata;
            end else begin
                r_key_high <= pwdata;
            end
        end
    end

    // Round logic
    assign ctl.round = r_round;
    assign ctl.last  = (r_round == ROUND_W'(NUM_ROUNDS));

    bc128_key_step u_key (
        .i_ctl (ctl),
        .i_rk  (r_rk),
        .o_rk  (rk_next)
    );

    bc128_round u_round (
        .i_ctl   (ctl),
        .i_state (r_blk),
        .i_rk    (rk_next),
        .o_state (round_out)
    );

    // Handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_blk       = r_blk;
        n_rk        = r_rk;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_rk    = {r_key_high, r_key_low};
                    n_blk   = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[BLOCK_W-1:HALF_W]}
                              ^ {r_key_high, r_key_low};
                    n_round = ROUND_W'(1);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_blk   = round_out;
                n_rk    = rk_next;
                n_round = r_round + ROUND_W'(1);
                if (ctl.last) begin
                    if (out_free) begin
                        n_out       = round_out;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out       = r_blk;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_rk  <= n_rk;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out[HALF_W-1:0], r_out[BLOCK_W-1:HALF_W]};

endmodule

`default_nettype wire

### hw/rtl/bc128_checker.sv
// ============================================================================
// bc128_checker - port-level checks for the block encryptor
// Watches the stream ports for round timing and result hold behavior.
// ============================================================================
`default_nettype none

module bc128_checker
    import bc128_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    input  wire logic                s_axis_tready,
    input  wire logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic [BLOCK_W-1:0]  m_axis_tdata
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // Drop ready for the rounds after a beat
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input ready right after a beat");

    // Stay busy through the last round
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> ##9 !s_axis_tready)
        else $error("input ready before the last round");

    // A new result only ends a busy spell
    a_result_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without rounds");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind block_cipher_128_encrypt bc128_checker u_bc128_checker (.*);

`default_nettype wire

### verif/tb_block_cipher_128_encrypt.sv
// ============================================================================
// tb_block_cipher_128_encrypt - self-checking bench for the AES-128 encryptor
// Computes each ciphertext with an in-bench AES-128 predictor, driven by a
// local copy of the key registers, and checks every output beat in order.
// Directed blocks cover the reset key, the standard known-answer vector and
// the extreme keys and blocks. Random phases follow, each with a fresh key
// and random plaintext, with input gaps and output stalls set by phase.
// ============================================================================

module tb_block_cipher_128_encrypt
    import bc128_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Byte addresses of the key registers
    typedef enum logic [3:0] {
        REG_KEY_HIGH = 4'h0,
        REG_KEY_LOW  = 4'h8
    } t_key_reg;

    typedef struct packed {
        logic [HALF_W-1:0] cipher_high;
        logic [HALF_W-1:0] cipher_low;
    } t_cipher_beat;

    localparam int unsigned RANDOM_PHASES  = 11;
    localparam int unsigned BLOCKS_PER_PHASE = 100;
    localparam int unsigned MAX_PRINTED    = 50;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [HALF_W-1:0]   pwdata;
    logic [HALF_W-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [BLOCK_W-1:0]  s_axis_tdata;   // [63:0] block_high, [127:64] block_low
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [BLOCK_W-1:0]  m_axis_tdata;   // [63:0] cipher_high, [127:64] cipher_low

    // Bench copy of the key registers and the ciphertexts still owed
    logic [HALF_W-1:0]   key_high_q;
    logic [HALF_W-1:0]   key_low_q;
    t_cipher_beat        expected_ciphers[$];
    int unsigned         mismatch_count;

    // Idling controls
    bit                  source_gaps;
    bit                  sink_stalls;
    int unsigned         stall_left;

    block_cipher_128_encrypt DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // AES-128 predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] gf_mul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 of key and block sits in the top bits
    function automatic logic [BLOCK_W-1:0] aes128_encrypt(input logic [BLOCK_W-1:0] key,
                                                          input logic [BLOCK_W-1:0] plain);
        logic [7:0]         round_keys [16*(NUM_ROUNDS+1)];
        logic [7:0]         st [16];
        logic [7:0]         shifted [16];
        logic [7:0]         tw [4];
        logic [7:0]         first, a0, a1, a2, a3, all;
        logic [BLOCK_W-1:0] res;
        for (int i = 0; i < 16; i++) begin
            round_keys[i] = key[BLOCK_W-1-8*i -: 8];
            st[i]         = plain[BLOCK_W-1-8*i -: 8] ^ round_keys[i];
        end
        // Expand the key one 32-bit word at a time
        for (int k = 4; k < 4*(NUM_ROUNDS+1); k++) begin
            for (int j = 0; j < 4; j++) tw[j] = round_keys[4*k-4+j];
            if (k % 4 == 0) begin
                first = tw[0];
                tw[0] = SBOX[tw[1]] ^ RCON[k/4];
                tw[1] = SBOX[tw[2]];
                tw[2] = SBOX[tw[3]];
                tw[3] = SBOX[first];
            end
            for (int j = 0; j < 4; j++) round_keys[4*k+j] = round_keys[4*(k-4)+j] ^ tw[j];
        end
        for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++) begin
            // Substitute and rotate row r left by r columns
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    shifted[4*c+r] = SBOX[st[4*((c+r)%4)+r]];
            // Mix each column, skipped in the last round
            for (int c = 0; c < 4; c++) begin
                a0 = shifted[4*c];
                a1 = shifted[4*c+1];
                a2 = shifted[4*c+2];
                a3 = shifted[4*c+3];
                if (rnd < NUM_ROUNDS) begin
                    all        = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]    = a0 ^ all ^ gf_mul2(a0 ^ a1);
                    st[4*c+1]  = a1 ^ all ^ gf_mul2(a1 ^ a2);
                    st[4*c+2]  = a2 ^ all ^ gf_mul2(a2 ^ a3);
                    st[4*c+3]  = a3 ^ all ^ gf_mul2(a3 ^ a0);
                end else begin
                    st[4*c]    = a0;
                    st[4*c+1]  = a1;
                    st[4*c+2]  = a2;
                    st[4*c+3]  = a3;
                end
            end
            for (int i = 0; i < 16; i++) st[i] = st[i] ^ round_keys[16*rnd+i];
        end
        for (int i = 0; i < 16; i++) res[BLOCK_W-1-8*i -: 8] = st[i];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Idle length: mostly short, some medium, a few long
    function automatic int unsigned pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Send one plaintext beat and record the ciphertext it owes
    task automatic send_block(input logic [HALF_W-1:0] blk_high,
                              input logic [HALF_W-1:0] blk_low);
        int unsigned  gap;
        logic [127:0] c;
        gap = (source_gaps && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {blk_low, blk_high};
        do @(posedge i_clk); while (!s_axis_tready);
        c = aes128_encrypt({key_high_q, key_low_q}, {blk_high, blk_low});
        expected_ciphers.push_back('{cipher_high: c[127:64], cipher_low: c[63:0]});
    endtask

    // Drop valid and hold until every owed ciphertext has come out
    task automatic wait_for_drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_ciphers.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_key_reg addr, input logic [HALF_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input t_key_reg addr, input logic [HALF_W-1:0] want);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("%s readback %h, want %h", addr.name(), prdata, want));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Load a new key once the block is idle, then read it back
    task automatic set_key(input logic [HALF_W-1:0] k_high, input logic [HALF_W-1:0] k_low);
        wait_for_drain();
        apb_write(REG_KEY_HIGH, k_high);
        key_high_q = k_high;
        apb_write(REG_KEY_LOW, k_low);
        key_low_q = k_low;
        apb_read_check(REG_KEY_HIGH, key_high_q);
        apb_read_check(REG_KEY_LOW, key_low_q);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and in-order check
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!sink_stalls) begin
            m_axis_tready = 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready = 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left    = pick_idle_len() - 1;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cipher_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_ciphers.size() == 0) begin
                report_mismatch($sformatf("ciphertext beat %h with no block outstanding",
                                          m_axis_tdata));
            end else begin
                want = expected_ciphers.pop_front();
                if (m_axis_tdata[63:0] !== want.cipher_high)
                    report_mismatch($sformatf("cipher_high %h, want %h",
                                              m_axis_tdata[63:0], want.cipher_high));
                if (m_axis_tdata[127:64] !== want.cipher_low)
                    report_mismatch($sformatf("cipher_low %h, want %h",
                                              m_axis_tdata[127:64], want.cipher_low));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Key registers come out of reset as zero
    task automatic test_reset_key();
        source_gaps = 0;
        sink_stalls = 0;
        apb_read_check(REG_KEY_HIGH, '0);
        apb_read_check(REG_KEY_LOW, '0);
        send_block('0, '0);
        send_block('1, '1);
        wait_for_drain();
    endtask

    // Standard known-answer vector, also a sanity check of the predictor
    task automatic test_known_answer();
        logic [127:0] c;
        c = aes128_encrypt(128'h000102030405060708090a0b0c0d0e0f,
                           128'h00112233445566778899aabbccddeeff);
        if (c !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a)
            report_mismatch($sformatf("predictor known answer %h", c));
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        wait_for_drain();
    endtask

    // Extreme keys and blocks, and a key change between blocks
    task automatic test_extreme_keys();
        set_key('1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        set_key('1, '0);
        send_block('0, '1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        set_key('0, '1);
        send_block('1, '0);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        set_key('0, '0);
        send_block('0, '0);
    endtask

    // Back-to-back blocks against a stalling sink so results back up
    task automatic test_back_to_back();
        source_gaps = 0;
        sink_stalls = 1;
        set_key(rand64(), rand64());
        for (int n = 0; n < 8; n++) send_block(rand64(), rand64());
        wait_for_drain();
    endtask

    // Random phases: new key each phase, varied idling, a mid-phase drain plus random drains
    task automatic test_random_traffic();
        logic [HALF_W-1:0] k_high, k_low;
        int unsigned       pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick = $urandom_range(0, 9);
            k_high = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
            pick = $urandom_range(0, 9);
            k_low  = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
            set_key(k_high, k_low);
            source_gaps = phase[0];
            sink_stalls = phase[1];
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                if (n == BLOCKS_PER_PHASE/2 || $urandom_range(0, 149) == 0)
                    wait_for_drain();
                send_block(rand64(), rand64());
            end
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = REG_KEY_HIGH;
        pwdata         = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b1;
        key_high_q     = '0;
        key_low_q      = '0;
        mismatch_count = 0;
        source_gaps    = 0;
        sink_stalls    = 0;
        stall_left     = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_known_answer();
        test_extreme_keys();
        test_back_to_back();
        test_random_traffic();

        // Settle past the block latency and look for stray beats
        sink_stalls = 0;
        wait_for_drain();
        repeat (24) @(posedge i_clk);
        if (mismatch_count == 0 && expected_ciphers.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #12ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
